### hdl/aksc_pkg.sv
// shared types, byte codes and key tables for the terminal key decoder
`timescale 1ns / 1ps
`default_nettype none
package aksc_pkg;

  typedef logic [7:0] byte_t;

  // one decoded key leaving the decoder
  typedef struct packed {
    logic  emit;
    byte_t scan_code;
    byte_t char_code;
  } aksc_key_t;

  localparam byte_t BYTE_NUL   = 8'h00;
  localparam byte_t BYTE_BS    = 8'h08;
  localparam byte_t BYTE_TAB   = 8'h09;
  localparam byte_t BYTE_CR    = 8'h0D;
  localparam byte_t BYTE_CTRL_Z = 8'h1A;
  localparam byte_t BYTE_ESC   = 8'h1B;
  localparam byte_t BYTE_SPACE = 8'h20;
  localparam byte_t BYTE_ZERO  = 8'h30;
  localparam byte_t BYTE_NINE  = 8'h39;
  localparam byte_t BYTE_PAR_HI = 8'h3F;
  localparam byte_t BYTE_FIN_LO = 8'h40;
  localparam byte_t BYTE_TILDE = 8'h7E;
  localparam byte_t BYTE_DEL   = 8'h7F;
  localparam byte_t BYTE_CSI   = 8'h5B; // '['
  localparam byte_t BYTE_SS3   = 8'h4F; // 'O'
  localparam byte_t BYTE_LOW_A = 8'h61;
  localparam byte_t BYTE_LOW_Z = 8'h7A;
  localparam byte_t BYTE_UP_A  = 8'h41;
  localparam byte_t BYTE_UP_B  = 8'h42;
  localparam byte_t BYTE_UP_C  = 8'h43;
  localparam byte_t BYTE_UP_D  = 8'h44;
  localparam byte_t BYTE_UP_F  = 8'h46;
  localparam byte_t BYTE_UP_H  = 8'h48;
  localparam byte_t BYTE_UP_P  = 8'h50;
  localparam byte_t BYTE_UP_Q  = 8'h51;
  localparam byte_t BYTE_UP_R  = 8'h52;
  localparam byte_t BYTE_UP_S  = 8'h53;

  localparam byte_t SC_NONE   = 8'h00;
  localparam byte_t SC_ESC    = 8'h01;
  localparam byte_t SC_BKSP   = 8'h0E;
  localparam byte_t SC_TAB    = 8'h0F;
  localparam byte_t SC_ENTER  = 8'h1C;
  localparam byte_t SC_UP     = 8'h48;
  localparam byte_t SC_DOWN   = 8'h50;
  localparam byte_t SC_RIGHT  = 8'h4D;
  localparam byte_t SC_LEFT   = 8'h4B;
  localparam byte_t SC_HOME   = 8'h47;
  localparam byte_t SC_END    = 8'h4F;
  localparam byte_t SC_F1     = 8'h3B;
  localparam byte_t SC_F2     = 8'h3C;
  localparam byte_t SC_F3     = 8'h3D;
  localparam byte_t SC_F4     = 8'h3E;

  localparam byte_t PARAM_MAX = 8'hFF;

  localparam byte_t SCAN_TABLE [128] = '{
    8'h00,8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22, 8'h0E,8'h0F,8'h1C,8'h25,8'h26,8'h1C,8'h31,8'h18,
    8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11, 8'h2D,8'h15,8'h2C,8'h01,8'h2B,8'h1B,8'h07,8'h0C,
    8'h39,8'h02,8'h28,8'h04,8'h05,8'h06,8'h08,8'h28, 8'h0A,8'h0B,8'h09,8'h0D,8'h33,8'h0C,8'h34,8'h35,
    8'h0B,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08, 8'h09,8'h0A,8'h27,8'h27,8'h33,8'h0D,8'h34,8'h35,
    8'h03,8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22, 8'h23,8'h17,8'h24,8'h25,8'h26,8'h32,8'h31,8'h18,
    8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11, 8'h2D,8'h15,8'h2C,8'h1A,8'h2B,8'h1B,8'h07,8'h0C,
    8'h29,8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22, 8'h23,8'h17,8'h24,8'h25,8'h26,8'h32,8'h31,8'h18,
    8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11, 8'h2D,8'h15,8'h2C,8'h1A,8'h2B,8'h1B,8'h29,8'h0E
  };

  // arrow keys shared by csi and ss3 finals
  function automatic byte_t cursor_key(input byte_t b);
    byte_t sc;
    case (b)
      BYTE_UP_A: sc = SC_UP;
      BYTE_UP_B: sc = SC_DOWN;
      BYTE_UP_C: sc = SC_RIGHT;
      BYTE_UP_D: sc = SC_LEFT;
      default:   sc = SC_NONE;
    endcase
    return sc;
  endfunction

  // editing, page and function keys selected by the csi parameter before '~'
  function automatic byte_t tilde_key(input byte_t p);
    byte_t sc;
    case (p)
      8'd1:    sc = 8'h47;
      8'd2:    sc = 8'h52;
      8'd3:    sc = 8'h53;
      8'd4:    sc = 8'h4F;
      8'd5:    sc = 8'h49;
      8'd6:    sc = 8'h51;
      8'd11:   sc = 8'h3B;
      8'd12:   sc = 8'h3C;
      8'd13:   sc = 8'h3D;
      8'd14:   sc = 8'h3E;
      8'd15:   sc = 8'h3F;
      8'd17:   sc = 8'h40;
      8'd18:   sc = 8'h41;
      8'd19:   sc = 8'h42;
      8'd20:   sc = 8'h43;
      8'd21:   sc = 8'h44;
      8'd23:   sc = 8'h85;
      8'd24:   sc = 8'h86;
      default: sc = SC_NONE;
    endcase
    return sc;
  endfunction

endpackage
`default_nettype wire

### hdl/aksc_decode.sv
// parser state and one-byte key decode for the terminal key decoder
`timescale 1ns / 1ps
`default_nettype none
module aksc_decode
  import aksc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire byte_t     byte_in,
  output aksc_key_t      key
);

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_ESC    = 2'd1;
  localparam logic [1:0] ST_CSI    = 2'd2;
  localparam logic [1:0] ST_SS3    = 2'd3;

  logic [1:0] state_r, state_nxt;
  byte_t      param_r, param_nxt;
  logic       done_r, done_nxt;
  logic [11:0] param_acc;
  byte_t      fin_sc;

  // param * 10 + digit, saturated
  assign param_acc = {1'b0, param_r, 3'b000} + {3'b000, param_r, 1'b0}
                   + {8'h00, byte_in[3:0]};

  always_comb begin
    state_nxt     = state_r;
    param_nxt     = param_r;
    done_nxt      = done_r;
    key.emit      = 1'b0;
    key.scan_code = SC_NONE;
    key.char_code = BYTE_NUL;
    fin_sc        = SC_NONE;
    case (state_r)
      ST_NORMAL: begin
        if (byte_in == BYTE_ESC) begin
          state_nxt = ST_ESC;
        end else if (byte_in == BYTE_DEL) begin
          key = '{1'b1, SC_BKSP, BYTE_BS};
        end else if (byte_in < BYTE_SPACE) begin
          if (byte_in == BYTE_CR) begin
            key = '{1'b1, SC_ENTER, BYTE_CR};
          end else if (byte_in == BYTE_TAB) begin
            key = '{1'b1, SC_TAB, BYTE_TAB};
          end else if (byte_in == BYTE_BS) begin
            key = '{1'b1, SC_BKSP, BYTE_BS};
          end else if (byte_in != BYTE_NUL && byte_in <= BYTE_CTRL_Z) begin
            // ctrl letter maps to its lower-case letter key
            key = '{1'b1, SCAN_TABLE[{2'b11, byte_in[4:0]}], byte_in};
          end
        end else if (!byte_in[7]) begin
          key = '{1'b1, SCAN_TABLE[byte_in[6:0]], byte_in};
        end
      end
      ST_ESC: begin
        if (byte_in == BYTE_CSI) begin
          state_nxt = ST_CSI;
          param_nxt = '0;
          done_nxt  = 1'b0;
        end else if (byte_in == BYTE_SS3) begin
          state_nxt = ST_SS3;
        end else begin
          state_nxt = ST_NORMAL;
          if (byte_in inside {[BYTE_LOW_A:BYTE_LOW_Z]}) begin
            key = '{1'b1, SCAN_TABLE[byte_in[6:0]], BYTE_NUL};
          end else begin
            key = '{1'b1, SC_ESC, BYTE_ESC};
          end
        end
      end
      ST_CSI: begin
        if (byte_in inside {[BYTE_ZERO:BYTE_PAR_HI]}) begin
          if (!done_r) begin
            if (byte_in <= BYTE_NINE) begin
              param_nxt = (param_acc > 12'(PARAM_MAX)) ? PARAM_MAX : param_acc[7:0];
            end else begin
              done_nxt = 1'b1;
            end
          end
        end else begin
          state_nxt = ST_NORMAL;
          param_nxt = '0;
          done_nxt  = 1'b0;
          if (byte_in inside {[BYTE_FIN_LO:BYTE_TILDE]}) begin
            if (byte_in == BYTE_UP_H) fin_sc = SC_HOME;
            else if (byte_in == BYTE_UP_F) fin_sc = SC_END;
            else if (byte_in == BYTE_TILDE) fin_sc = tilde_key(param_r);
            else fin_sc = cursor_key(byte_in);
            key = '{(fin_sc != SC_NONE), fin_sc, BYTE_NUL};
          end
        end
      end
      default: begin
        state_nxt = ST_NORMAL;
        if (byte_in == BYTE_UP_P) fin_sc = SC_F1;
        else if (byte_in == BYTE_UP_Q) fin_sc = SC_F2;
        else if (byte_in == BYTE_UP_R) fin_sc = SC_F3;
        else if (byte_in == BYTE_UP_S) fin_sc = SC_F4;
        else fin_sc = cursor_key(byte_in);
        key = '{(fin_sc != SC_NONE), fin_sc, BYTE_NUL};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NORMAL;
      param_r <= '0;
      done_r  <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
      param_r <= param_nxt;
      done_r  <= done_nxt;
    end
  end

  // parameter bookkeeping only lives inside a csi sequence
  a_done_in_csi: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == ST_CSI) else $error("digit freeze set outside csi");
  a_param_in_csi: assert property (@(posedge clk) disable iff (!rst_n)
    param_r != '0 |-> state_r == ST_CSI) else $error("csi parameter left over");

endmodule
`default_nettype wire

### hdl/ansi_key_sequence_to_scancode_unit.sv
// top level: terminal byte stream to pc scan code and character pairs
//
// Each accepted byte lands in an input register, is decoded against the parser
// state as it moves on from that register and, if it completes a key, the
// scan code and character land in the output register. One byte can be taken
// every cycle while the result side keeps up; a byte that yields no key (escape
// and sequence bytes, unmapped codes) produces no output transaction.
// Throughput is set by the single parser state register, which is updated once
// per byte.
`timescale 1ns / 1ps
`default_nettype none
module ansi_key_sequence_to_scancode_unit
  import aksc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire byte_t in_byte,
  output logic       out_valid,
  input  wire logic  out_stall,
  output byte_t      out_scan_code,
  output byte_t      out_char_code
);

  logic      s1_valid_r;
  byte_t     s1_byte_r;
  logic      out_valid_r;
  byte_t     out_scan_r;
  byte_t     out_char_r;
  logic      out_free;
  logic      s1_adv;
  logic      in_take;
  aksc_key_t key;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  aksc_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_adv),
    .byte_in (s1_byte_r),
    .key     (key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_adv && key.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte;
    end
    if (s1_adv && key.emit) begin
      out_scan_r <= key.scan_code;
      out_char_r <= key.char_code;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scan_code = out_scan_r;
  assign out_char_code = out_char_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r) else $error("input stalled with empty input register");
  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_byte_r))
    else $error("held input byte lost");
  a_out_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("output transaction without decoded byte");

endmodule
`default_nettype wire

### tb/key_decode_checker.sv
// checker for the terminal key decoder: predicts keys from accepted bytes and compares
`timescale 1ns / 1ps
module key_decode_checker
  import aksc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_stall,
  input  byte_t in_byte,
  input  logic  out_valid,
  input  logic  out_stall,
  input  byte_t out_scan_code,
  input  byte_t out_char_code,
  output int    error_count,
  output int    outstanding
);

  typedef enum logic [1:0] {DEC_NORMAL, DEC_ESC, DEC_CSI, DEC_SS3} dec_state_t;

  // scan codes with no name in the package
  localparam byte_t SC_PGUP   = 8'h49;
  localparam byte_t SC_PGDN   = 8'h51;
  localparam byte_t SC_INSERT = 8'h52;
  localparam byte_t SC_DELETE = 8'h53;
  localparam byte_t SC_F5     = 8'h3F;
  localparam byte_t SC_F6     = 8'h40;
  localparam byte_t SC_F7     = 8'h41;
  localparam byte_t SC_F8     = 8'h42;
  localparam byte_t SC_F9     = 8'h43;
  localparam byte_t SC_F10    = 8'h44;
  localparam byte_t SC_F11    = 8'h85;
  localparam byte_t SC_F12    = 8'h86;

  // ascii to pc scan code, us layout
  localparam byte_t KEY_SCAN [128] = '{
    8'h00,8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22, 8'h0E,8'h0F,8'h1C,8'h25,8'h26,8'h1C,8'h31,8'h18,
    8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11, 8'h2D,8'h15,8'h2C,8'h01,8'h2B,8'h1B,8'h07,8'h0C,
    8'h39,8'h02,8'h28,8'h04,8'h05,8'h06,8'h08,8'h28, 8'h0A,8'h0B,8'h09,8'h0D,8'h33,8'h0C,8'h34,8'h35,
    8'h0B,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08, 8'h09,8'h0A,8'h27,8'h27,8'h33,8'h0D,8'h34,8'h35,
    8'h03,8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22, 8'h23,8'h17,8'h24,8'h25,8'h26,8'h32,8'h31,8'h18,
    8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11, 8'h2D,8'h15,8'h2C,8'h1A,8'h2B,8'h1B,8'h07,8'h0C,
    8'h29,8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22, 8'h23,8'h17,8'h24,8'h25,8'h26,8'h32,8'h31,8'h18,
    8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11, 8'h2D,8'h15,8'h2C,8'h1A,8'h2B,8'h1B,8'h29,8'h0E
  };

  dec_state_t dec_state = DEC_NORMAL;
  byte_t      csi_num = '0;
  bit         csi_num_frozen = 1'b0;
  aksc_key_t  expected_keys [$];
  int         mismatch_tally = 0;

  assign error_count = mismatch_tally;
  initial outstanding = 0;

  // final byte of a csi or ss3 sequence to its key, SC_NONE when unmapped
  function automatic byte_t sequence_key_scan(input byte_t fin, input bit after_csi,
                                              input byte_t vt_num);
    byte_t sc;
    sc = SC_NONE;
    case (fin)
      BYTE_UP_A: sc = SC_UP;
      BYTE_UP_B: sc = SC_DOWN;
      BYTE_UP_C: sc = SC_RIGHT;
      BYTE_UP_D: sc = SC_LEFT;
      BYTE_UP_H: if (after_csi) sc = SC_HOME;
      BYTE_UP_F: if (after_csi) sc = SC_END;
      BYTE_UP_P: if (!after_csi) sc = SC_F1;
      BYTE_UP_Q: if (!after_csi) sc = SC_F2;
      BYTE_UP_R: if (!after_csi) sc = SC_F3;
      BYTE_UP_S: if (!after_csi) sc = SC_F4;
      BYTE_TILDE: begin
        if (after_csi) begin
          case (vt_num)
            8'd1:    sc = SC_HOME;
            8'd2:    sc = SC_INSERT;
            8'd3:    sc = SC_DELETE;
            8'd4:    sc = SC_END;
            8'd5:    sc = SC_PGUP;
            8'd6:    sc = SC_PGDN;
            8'd11:   sc = SC_F1;
            8'd12:   sc = SC_F2;
            8'd13:   sc = SC_F3;
            8'd14:   sc = SC_F4;
            8'd15:   sc = SC_F5;
            8'd17:   sc = SC_F6;
            8'd18:   sc = SC_F7;
            8'd19:   sc = SC_F8;
            8'd20:   sc = SC_F9;
            8'd21:   sc = SC_F10;
            8'd23:   sc = SC_F11;
            8'd24:   sc = SC_F12;
            default: sc = SC_NONE;
          endcase
        end
      end
      default: sc = SC_NONE;
    endcase
    return sc;
  endfunction

  // advances the parser copy by one byte and returns the key it completes, if any
  function automatic aksc_key_t decode_terminal_byte(input byte_t b);
    aksc_key_t   k;
    byte_t       num;
    int unsigned acc;
    k = '{1'b0, SC_NONE, BYTE_NUL};
    case (dec_state)
      DEC_NORMAL: begin
        if (b == BYTE_ESC) dec_state = DEC_ESC;
        else if (b == BYTE_DEL) k = '{1'b1, SC_BKSP, BYTE_BS};
        else if (b == BYTE_CR) k = '{1'b1, SC_ENTER, BYTE_CR};
        else if (b == BYTE_TAB) k = '{1'b1, SC_TAB, BYTE_TAB};
        else if (b == BYTE_BS) k = '{1'b1, SC_BKSP, BYTE_BS};
        // ctrl letter takes the scan code of its lower-case letter
        else if (b != BYTE_NUL && b <= BYTE_CTRL_Z)
          k = '{1'b1, KEY_SCAN[b + BYTE_LOW_A - 8'd1], b};
        else if (b >= BYTE_SPACE && !b[7]) k = '{1'b1, KEY_SCAN[b], b};
      end
      DEC_ESC: begin
        if (b == BYTE_CSI) begin
          dec_state = DEC_CSI;
          csi_num = '0;
          csi_num_frozen = 1'b0;
        end else if (b == BYTE_SS3) begin
          dec_state = DEC_SS3;
        end else begin
          dec_state = DEC_NORMAL;
          if (b >= BYTE_LOW_A && b <= BYTE_LOW_Z) k = '{1'b1, KEY_SCAN[b], BYTE_NUL};
          else k = '{1'b1, SC_ESC, BYTE_ESC};
        end
      end
      DEC_CSI: begin
        if (b >= BYTE_ZERO && b <= BYTE_PAR_HI) begin
          // only the leading digits count, saturating
          if (!csi_num_frozen) begin
            if (b <= BYTE_NINE) begin
              acc = csi_num * 10 + (b - BYTE_ZERO);
              csi_num = (acc > PARAM_MAX) ? PARAM_MAX : acc[7:0];
            end else begin
              csi_num_frozen = 1'b1;
            end
          end
        end else begin
          dec_state = DEC_NORMAL;
          num = csi_num;
          csi_num = '0;
          csi_num_frozen = 1'b0;
          if (b >= BYTE_FIN_LO && b <= BYTE_TILDE) begin
            k.scan_code = sequence_key_scan(b, 1'b1, num);
            k.emit = (k.scan_code != SC_NONE);
          end
        end
      end
      default: begin
        dec_state = DEC_NORMAL;
        k.scan_code = sequence_key_scan(b, 1'b0, '0);
        k.emit = (k.scan_code != SC_NONE);
      end
    endcase
    return k;
  endfunction

  always @(posedge clk) begin
    aksc_key_t predicted;
    aksc_key_t oldest;
    if (!rst_n) begin
      dec_state = DEC_NORMAL;
      csi_num = '0;
      csi_num_frozen = 1'b0;
      expected_keys.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predicted = decode_terminal_byte(in_byte);
        if (predicted.emit) expected_keys = {expected_keys, predicted};
      end
      if (out_valid && !out_stall) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: unexpected key transaction, expected none actual scan %02h char %02h",
                   $time, out_scan_code, out_char_code);
          mismatch_tally++;
        end else begin
          oldest = expected_keys.pop_front();
          if (out_scan_code !== oldest.scan_code) begin
            $display("%0t: scan code mismatch, expected %02h actual %02h", $time,
                     oldest.scan_code, out_scan_code);
            mismatch_tally++;
          end
          if (out_char_code !== oldest.char_code) begin
            $display("%0t: char code mismatch, expected %02h actual %02h", $time,
                     oldest.char_code, out_char_code);
            mismatch_tally++;
          end
        end
      end
    end
    outstanding <= expected_keys.size();
  end

endmodule

### tb/ansi_key_sequence_to_scancode_unit_tb.sv
// testbench top: byte stimulus, result stalls and verdict for the terminal key decoder
`timescale 1ns / 1ps
module ansi_key_sequence_to_scancode_unit_tb;
  import aksc_pkg::*;

  typedef enum {RX_NO_STALL, RX_RANDOM_STALL, RX_LONG_STALL} rx_mode_t;

  // plain extremes, then one sample of each kind of sequence
  localparam byte_t OPENING_BYTES [26] = '{
    BYTE_NUL, 8'hFF, BYTE_DEL, BYTE_CR, BYTE_TAB, BYTE_BS, 8'h01, BYTE_CTRL_Z, 8'h1C,
    BYTE_SPACE, BYTE_TILDE,
    BYTE_ESC, BYTE_LOW_Z,
    BYTE_ESC, BYTE_ESC,
    BYTE_ESC, BYTE_CSI, 8'h32, 8'h34, BYTE_TILDE,
    BYTE_ESC, BYTE_SS3, BYTE_UP_S,
    BYTE_ESC, BYTE_CSI, 8'h05
  };

  localparam int VT_KEY_NUMS [18] = '{1, 2, 3, 4, 5, 6, 11, 12, 13, 14, 15, 17, 18, 19, 20,
                                      21, 23, 24};
  localparam byte_t CURSOR_FINALS [6] = '{BYTE_UP_A, BYTE_UP_B, BYTE_UP_C, BYTE_UP_D,
                                          BYTE_UP_H, BYTE_UP_F};
  localparam byte_t SS3_FINALS [8] = '{BYTE_UP_A, BYTE_UP_B, BYTE_UP_C, BYTE_UP_D,
                                       BYTE_UP_P, BYTE_UP_Q, BYTE_UP_R, BYTE_UP_S};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  byte_t    in_byte = BYTE_NUL;
  logic     out_valid;
  logic     out_stall = 1'b0;
  byte_t    out_scan_code;
  byte_t    out_char_code;
  int       error_count;
  int       outstanding;
  rx_mode_t rx_mode = RX_NO_STALL;
  int       max_gap = 0;
  int       burst_left = 0;
  int       bytes_sent = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  ansi_key_sequence_to_scancode_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scan_code(out_scan_code),
    .out_char_code(out_char_code)
  );

  key_decode_checker u_key_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scan_code(out_scan_code),
    .out_char_code(out_char_code),
    .error_count  (error_count),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    case (rx_mode)
      RX_NO_STALL:     out_stall <= 1'b0;
      RX_RANDOM_STALL: out_stall <= ($urandom_range(0, 2) == 0);
      // rare toggles give long stall and long open stretches
      default:         out_stall <= ($urandom_range(0, 11) == 0) ? !out_stall : out_stall;
    endcase
  end

  task automatic send_byte(input byte_t b);
    int gap;
    if (burst_left == 0) begin
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_number(input int unsigned n);
    string digits;
    int    i;
    digits = $sformatf("%0d", n);
    for (i = 0; i < digits.len(); i++) send_byte(byte_t'(digits[i]));
  endtask

  // param bytes of any kind: digits, separators and the other 0x3a-0x3f bytes
  task automatic send_csi_params(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) send_byte(byte_t'($urandom_range(BYTE_ZERO, BYTE_PAR_HI)));
      else send_byte(byte_t'($urandom_range(BYTE_ZERO, BYTE_NINE)));
    end
  endtask

  task automatic send_csi_key();
    int unsigned num;
    int          pick;
    send_byte(BYTE_ESC);
    send_byte(BYTE_CSI);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      case ($urandom_range(0, 5))
        0:       num = $urandom_range(0, 30);
        1:       num = $urandom_range(0, 3000);
        2:       num = 256 + VT_KEY_NUMS[$urandom_range(0, 17)];
        default: num = VT_KEY_NUMS[$urandom_range(0, 17)];
      endcase
      if ($urandom_range(0, 7) == 0) send_byte(BYTE_ZERO);
      if ($urandom_range(0, 9) != 0) send_number(num);
      // modifier suffix after a separator
      if ($urandom_range(0, 5) == 0) begin
        send_byte(byte_t'($urandom_range(8'h3A, BYTE_PAR_HI)));
        send_csi_params($urandom_range(0, 3));
      end
      send_byte(BYTE_TILDE);
    end else begin
      send_csi_params($urandom_range(0, 3));
      if (pick < 8) send_byte(CURSOR_FINALS[$urandom_range(0, 5)]);
      else send_byte(byte_t'($urandom_range(BYTE_FIN_LO, BYTE_TILDE)));
    end
  endtask

  task automatic send_broken_sequence();
    send_byte(BYTE_ESC);
    case ($urandom_range(0, 3))
      0: send_byte(byte_t'($urandom_range(0, 255)));
      1: begin
        send_byte(BYTE_SS3);
        send_byte(byte_t'($urandom_range(0, 255)));
      end
      default: begin
        send_byte(BYTE_CSI);
        send_csi_params($urandom_range(0, 4));
        if ($urandom_range(0, 1) == 0) send_byte(byte_t'($urandom_range(BYTE_NUL, 8'h2F)));
        else send_byte(byte_t'($urandom_range(BYTE_DEL, 8'hFF)));
      end
    endcase
  endtask

  task automatic send_random_keys(input int target);
    int stop_at;
    int pick;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_byte(byte_t'($urandom_range(0, 255)));
      end else if (pick < 40) begin
        send_byte(byte_t'($urandom_range(0, BYTE_DEL)));
      end else if (pick < 62) begin
        send_csi_key();
      end else if (pick < 74) begin
        send_byte(BYTE_ESC);
        send_byte(BYTE_SS3);
        send_byte(SS3_FINALS[$urandom_range(0, 7)]);
      end else if (pick < 84) begin
        send_byte(BYTE_ESC);
        send_byte(byte_t'($urandom_range(BYTE_LOW_A, BYTE_LOW_Z)));
      end else begin
        send_broken_sequence();
      end
    end
  endtask

  // hold the sender until every predicted key has come out
  task automatic drain_keys();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int gap_limit, input rx_mode_t mode, input int target);
    max_gap = gap_limit;
    burst_left = 0;
    rx_mode <= mode;
    send_random_keys(target);
    drain_keys();
  endtask

  initial begin
    int i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < 26; i++) send_byte(OPENING_BYTES[i]);
    drain_keys();
    run_phase(0, RX_NO_STALL, 400);
    run_phase(8, RX_RANDOM_STALL, 600);
    run_phase(3, RX_LONG_STALL, 500);
    run_phase(0, RX_RANDOM_STALL, 250);
    run_phase(12, RX_NO_STALL, 250);
    repeat (10) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
hdl/aksc_pkg.sv
hdl/aksc_decode.sv
hdl/ansi_key_sequence_to_scancode_unit.sv
tb/key_decode_checker.sv
tb/ansi_key_sequence_to_scancode_unit_tb.sv
